### hw/rtl/upcsm_pkg.sv
// Shared types, codes and sizes for the USB port connection state machine.
`default_nettype none
package upcsm_pkg;

    // Table size and widths
    localparam int NUM_PORTS = 16;
    localparam int IDX_W     = $clog2(NUM_PORTS);
    localparam int PORT_W    = 4;
    localparam int PAIR_W    = 5;
    localparam int STATE_W   = 3;
    localparam int ACT_W     = 2;
    localparam int CLS_W     = 2;
    localparam int KIND_W    = 2;
    localparam int SPEED_W   = 4;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 8;
    localparam int QDEPTH    = 2;

    // Port connection states
    localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] ST_SPUR  = 3'd1;
    localparam logic [STATE_W-1:0] ST_RESET = 3'd2;
    localparam logic [STATE_W-1:0] ST_INIT  = 3'd3;
    localparam logic [STATE_W-1:0] ST_RUN   = 3'd4;

    // Actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_WARN  = 2'd3;

    // Event classes
    localparam logic [CLS_W-1:0] EV_NONE = 2'd0;
    localparam logic [CLS_W-1:0] EV_CFG  = 2'd1;
    localparam logic [CLS_W-1:0] EV_RST  = 2'd2;
    localparam logic [CLS_W-1:0] EV_CONN = 2'd3;

    // Protocol kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_USB2 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_USB3 = 2'd2;

    localparam logic [PAIR_W-1:0] NO_PAIR = 5'd16;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    // Classified item passed from front to back
    typedef struct packed {
        logic              load;
        logic              oob;
        logic [CLS_W-1:0]  ev;
        logic [IDX_W-1:0]  port;
        logic              paired;
        logic [IDX_W-1:0]  pair;
        logic [KIND_W-1:0] kind;
        logic              conn;
        logic              en;
        logic              spd_nz;
        logic              seen;
    } upcsm_entry_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } upcsm_qstat_t;

    function automatic logic is_active(input logic [STATE_W-1:0] s);
        return (s == ST_RESET) || (s == ST_INIT) || (s == ST_RUN);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/upcsm_front.sv
// Front end: accepts items, keeps the kind and pair table, classifies events.
`default_nettype none
module upcsm_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [upcsm_pkg::IN_W-1:0] in_data,
    input  wire logic                       in_mode,
    input  wire upcsm_pkg::upcsm_qstat_t    qstat,
    output logic                            push,
    output upcsm_pkg::upcsm_entry_t         entry
);
    import upcsm_pkg::*;

    logic [KIND_W-1:0] kind_reg [NUM_PORTS];
    logic [PAIR_W-1:0] pair_reg [NUM_PORTS];

    logic [PORT_W-1:0]  f_port;
    logic [KIND_W-1:0]  f_proto;
    logic [PAIR_W-1:0]  f_pair;
    logic               f_cc, f_rc, f_ce;
    logic [SPEED_W-1:0] f_speed;
    logic               oob;
    logic [IDX_W-1:0]   idx;
    logic [PAIR_W-1:0]  cur_pair;

    // Unpack the transaction
    assign f_port  = in_data[3:0];
    assign f_proto = in_data[5:4];
    assign f_pair  = in_data[10:6];
    assign f_cc    = in_data[11];
    assign f_rc    = in_data[12];
    assign f_ce    = in_data[13];
    assign f_speed = in_data[19:16];

    assign oob      = int'(f_port) >= NUM_PORTS;
    assign idx      = f_port[IDX_W-1:0];
    assign cur_pair = kind_pair_sel(idx);

    function automatic logic [PAIR_W-1:0] kind_pair_sel(input logic [IDX_W-1:0] i);
        return pair_reg[i];
    endfunction

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    // Classify by priority: config error, reset change, connect change; load items carry no event
    always_comb
    begin
        entry        = '0;
        entry.load   = (in_mode == MODE_LOAD);
        entry.oob    = oob;
        entry.port   = idx;
        entry.paired = (cur_pair != NO_PAIR) && (int'(cur_pair) < NUM_PORTS);
        entry.pair   = cur_pair[IDX_W-1:0];
        entry.kind   = kind_reg[idx];
        entry.conn   = in_data[14];
        entry.en     = in_data[15];
        entry.spd_nz = (f_speed != '0);
        entry.seen   = in_data[20];
        priority if (in_mode == MODE_LOAD)
            entry.ev = EV_NONE;
        else if (f_ce)
            entry.ev = EV_CFG;
        else if (f_rc)
            entry.ev = EV_RST;
        else if (f_cc)
            entry.ev = EV_CONN;
        else
            entry.ev = EV_NONE;
    end

    // Store kind and pair on a load to an in-range port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                kind_reg[i] <= KIND_NONE;
                pair_reg[i] <= NO_PAIR;
            end
        end
        else if (push && (in_mode == MODE_LOAD) && !oob)
        begin
            kind_reg[idx] <= f_proto;
            pair_reg[idx] <= f_pair;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/upcsm_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module upcsm_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire upcsm_pkg::upcsm_entry_t  push_entry,
    input  wire logic                     pop,
    output upcsm_pkg::upcsm_entry_t       head,
    output upcsm_pkg::upcsm_qstat_t       qstat
);
    import upcsm_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    upcsm_entry_t     slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/upcsm_back.sv
// Back end: state memory, event execution and the result register.
`default_nettype none
module upcsm_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire upcsm_pkg::upcsm_entry_t     head,
    input  wire upcsm_pkg::upcsm_qstat_t     qstat,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [upcsm_pkg::OUT_W-1:0]      out_data
);
    import upcsm_pkg::*;

    localparam logic BK_READ = 1'b0;
    localparam logic BK_EXEC = 1'b1;

    logic                 bk_reg, bk_next;
    logic [STATE_W-1:0]   mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] vld_reg;
    logic [STATE_W-1:0]   own_rd_reg, pair_rd_reg;
    logic                 own_vld_reg, pair_vld_reg;
    upcsm_entry_t         cur_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic               slot_free, exec_done, wr_en;
    logic [STATE_W-1:0] st, pst, new_st;
    logic [ACT_W-1:0]   act;
    logic [CLS_W-1:0]   cls;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (bk_reg == BK_READ) && !qstat.empty;
    assign exec_done = (bk_reg == BK_EXEC) && slot_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read own and pair state
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            own_rd_reg  <= mem[head.port];
            pair_rd_reg <= mem[head.pair];
            own_vld_reg <= vld_reg[head.port];
            pair_vld_reg <= vld_reg[head.pair];
            cur_reg     <= head;
        end
        if (wr_en)
            mem[cur_reg.port] <= new_st;
    end

    assign st  = own_vld_reg ? own_rd_reg : ST_IDLE;
    assign pst = (cur_reg.paired && pair_vld_reg) ? pair_rd_reg : ST_IDLE;

    // Carry out the event
    always_comb
    begin
        new_st = st;
        act    = ACT_NONE;
        cls    = cur_reg.ev;
        unique case (cur_reg.ev)
            EV_CFG:
            begin
                new_st = ST_IDLE;
                act    = ACT_WARN;
            end
            EV_RST:
            begin
                priority if (st != ST_RESET)
                    act = ACT_WARN;
                else if (!(cur_reg.en && cur_reg.spd_nz))
                    new_st = ST_IDLE;
                else
                    act = ACT_INIT;
            end
            EV_CONN:
            begin
                priority if (!cur_reg.conn && (st == ST_SPUR))
                    new_st = ST_IDLE;
                else if (is_active(pst))
                    act = ACT_NONE;
                else if (!cur_reg.conn && is_active(st))
                    new_st = ST_IDLE;
                else if (!cur_reg.conn)
                    act = ACT_WARN;
                else if ((cur_reg.kind == KIND_USB2) && cur_reg.paired
                         && (pst != ST_IDLE))
                    act = ACT_WARN;
                else if ((cur_reg.kind == KIND_USB2) && cur_reg.paired && cur_reg.seen)
                    new_st = ST_SPUR;
                else if ((cur_reg.kind == KIND_USB3) && !(cur_reg.en && cur_reg.spd_nz))
                    new_st = ST_IDLE;
                else if (cur_reg.kind == KIND_USB3)
                    act = ACT_INIT;
                else
                begin
                    new_st = ST_RESET;
                    act    = ACT_RESET;
                end
            end
            default:
            begin
                new_st = st;
            end
        endcase
        if (cur_reg.load)
        begin
            act = ACT_NONE;
            cls = EV_NONE;
        end
        if (cur_reg.oob)
        begin
            new_st = ST_IDLE;
            act    = ACT_NONE;
            cls    = EV_NONE;
        end
    end

    assign wr_en = exec_done && !cur_reg.oob && !cur_reg.load;

    // Sequencer
    always_comb
    begin
        bk_next = bk_reg;
        unique case (bk_reg)
            BK_READ: if (pop) bk_next = BK_EXEC;
            BK_EXEC: if (slot_free) bk_next = BK_READ;
            default: bk_next = BK_READ;
        endcase
    end

    // Hold result until taken
    always_ff @(posedge clk)
    begin
        if (exec_done)
            out_data_reg <= {1'b0, cls, act, new_st};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_reg        <= BK_READ;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bk_reg <= bk_next;
            if (wr_en)
                vld_reg[cur_reg.port] <= 1'b1;
            if (exec_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/usb_port_connection_state_machine_core.sv
// Top level of the USB port connection state machine.
// Flow: an accepted item is written into the queue, popped into the read
// registers, then executed into the result register, held there until taken.
// The back end reads then executes one item at a time on the state memory's
// registered read ports; a 2-entry queue decouples input. Reset: all ports
// idle, not present, unpaired, per-port valid bits clear; items taken at once.
`default_nettype none
module usb_port_connection_state_machine_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // port_index[3:0], port_protocol[5:4], pair_index[10:6], connect_change[11],
    // reset_change[12], config_error[13], connected[14], enabled[15],
    // port_speed[19:16], pair_connect_seen[20], zero[23:21]
    input  wire logic [upcsm_pkg::IN_W-1:0]  s_axis_tdata,
    // mode[0]
    input  wire logic [0:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // new_state[2:0], action[4:3], event_class[6:5], zero[7]
    output logic [upcsm_pkg::OUT_W-1:0]      m_axis_tdata
);
    import upcsm_pkg::*;

    upcsm_entry_t push_entry, head;
    upcsm_qstat_t qstat;
    logic         push, pop;

    upcsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_mode  (s_axis_tuser[0]),
        .qstat    (qstat),
        .push     (push),
        .entry    (push_entry)
    );

    upcsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    upcsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // A port reset is only issued together with the resetting state
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[4:3] == ACT_RESET) |-> (m_axis_tdata[2:0] == ST_RESET))
        else $error("port reset issued without resetting state");

    // A config error always leaves the port idle with a warning
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[6:5] == EV_CFG)
        |-> (m_axis_tdata[2:0] == ST_IDLE) && (m_axis_tdata[4:3] == ACT_WARN))
        else $error("config error result wrong");

    // Without an event there is no action
    a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[6:5] == EV_NONE) |-> (m_axis_tdata[4:3] == ACT_NONE))
        else $error("action without event");

    // The back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue underflow");

endmodule
`default_nettype wire

### tb/sv/tb_usb_port_connection_state_machine_core.sv
// Self-checking stream testbench for the USB port connection state machine core.
`timescale 1ns / 100ps

module tb_usb_port_connection_state_machine_core;

    import upcsm_pkg::*;

    localparam int RAND_ITEMS   = 1750;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 600000;

    // One port item as it travels on the slave side
    typedef struct packed {
        logic                mode;
        logic [PORT_W-1:0]   port;
        logic [KIND_W-1:0]   proto;
        logic [PAIR_W-1:0]   pair;
        logic                cc;
        logic                rc;
        logic                ce;
        logic                conn;
        logic                en;
        logic [SPEED_W-1:0]  speed;
        logic                seen;
    } port_item_t;

    // One status result as it travels on the master side
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [ACT_W-1:0]   act;
        logic [CLS_W-1:0]   cls;
    } port_result_t;

    typedef struct packed {
        port_item_t   item;
        logic         typed;
        port_result_t res;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // port_index, port_protocol, pair_index, connect_change, reset_change,
    // config_error, connected, enabled, port_speed, pair_connect_seen, zero pad
    logic [IN_W-1:0]      s_axis_tdata;
    // mode
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // new_state, action, event_class, zero pad
    logic [OUT_W-1:0]     m_axis_tdata;

    // Shadow copy of the port table
    logic [STATE_W-1:0]   state_tbl [NUM_PORTS];
    logic [KIND_W-1:0]    kind_tbl  [NUM_PORTS];
    logic [PAIR_W-1:0]    pair_tbl  [NUM_PORTS];

    port_result_t         expected_status_q [$];
    plan_row_t            plan [$];

    // Typed expectation that travels alongside the current transaction
    logic                 typed_row;
    port_result_t         typed_res;

    port_item_t           taken_item;
    port_result_t         taken_res;
    port_result_t         want_res;
    int                   errors;
    int                   cycles;
    logic                 hold_req;
    logic                 calm;

    usb_port_connection_state_machine_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Abort a run that hangs
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic port_busy(input logic [STATE_W-1:0] s);
        return (s == ST_RESET) || (s == ST_INIT) || (s == ST_RUN);
    endfunction

    // Connect change handling; updates the port's state and returns the action
    function automatic logic [ACT_W-1:0] connect_action(input port_item_t it);
        logic [IDX_W-1:0]   p;
        logic [STATE_W-1:0] st;
        logic [PAIR_W-1:0]  pl;
        logic               paired;
        logic [STATE_W-1:0] pst;
        p      = it.port[IDX_W-1:0];
        st     = state_tbl[p];
        pl     = pair_tbl[p];
        paired = (pl != NO_PAIR) && (int'(pl) < NUM_PORTS);
        pst    = paired ? state_tbl[pl[IDX_W-1:0]] : ST_IDLE;
        // Disconnect clears a spurious port before looking at the pair
        if (!it.conn && st == ST_SPUR)
        begin
            state_tbl[p] = ST_IDLE;
            return ACT_NONE;
        end
        // Leave it to a pair that is already in use
        if (port_busy(pst))
            return ACT_NONE;
        if (!it.conn && port_busy(st))
        begin
            state_tbl[p] = ST_IDLE;
            return ACT_NONE;
        end
        if (!it.conn)
            return ACT_WARN;
        // USB2 side of a pair yields when the USB3 side came up
        if (it.conn && kind_tbl[p] == KIND_USB2 && paired)
        begin
            if (pst != ST_IDLE)
                return ACT_WARN;
            if (it.seen)
            begin
                state_tbl[p] = ST_SPUR;
                return ACT_NONE;
            end
        end
        if (kind_tbl[p] == KIND_USB3)
        begin
            if (!(it.en && it.speed != '0))
            begin
                state_tbl[p] = ST_IDLE;
                return ACT_NONE;
            end
            return ACT_INIT;
        end
        // Anything else is reset, unknown kinds included
        state_tbl[p] = ST_RESET;
        return ACT_RESET;
    endfunction

    // Apply one item to the shadow table and give the status it causes
    function automatic port_result_t advance_port(input port_item_t it);
        port_result_t     r;
        logic [IDX_W-1:0] p;
        p     = it.port[IDX_W-1:0];
        r.act = ACT_NONE;
        r.cls = EV_NONE;
        if (int'(it.port) >= NUM_PORTS)
        begin
            r.state = ST_IDLE;
            return r;
        end
        if (it.mode == MODE_LOAD)
        begin
            kind_tbl[p] = it.proto;
            pair_tbl[p] = it.pair;
        end
        else if (it.ce)
        begin
            r.cls        = EV_CFG;
            state_tbl[p] = ST_IDLE;
            r.act        = ACT_WARN;
        end
        else if (it.rc)
        begin
            r.cls = EV_RST;
            if (state_tbl[p] != ST_RESET)
                r.act = ACT_WARN;
            else if (!(it.en && it.speed != '0))
                state_tbl[p] = ST_IDLE;
            else
                r.act = ACT_INIT;
        end
        else if (it.cc)
        begin
            r.cls = EV_CONN;
            r.act = connect_action(it);
        end
        r.state = state_tbl[p];
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random item, biased towards a few hot ports and well-formed pairings
    function automatic port_item_t random_item();
        port_item_t it;
        int         r;
        it = port_item_t'($bits(port_item_t)'($urandom));
        it.port = ($urandom_range(0, 99) < 60) ? PORT_W'($urandom_range(0, 5))
                                               : PORT_W'($urandom_range(0, 15));
        it.mode = ($urandom_range(0, 99) < 12) ? MODE_LOAD : MODE_EVENT;
        if (it.mode == MODE_LOAD)
        begin
            r = $urandom_range(0, 99);
            it.proto = (r < 45) ? KIND_USB2 : (r < 85) ? KIND_USB3 :
                       (r < 95) ? KIND_NONE : KIND_W'(3);
            r = $urandom_range(0, 99);
            if (r < 30)
                it.pair = NO_PAIR;
            else if (r < 80)
                it.pair = PAIR_W'(it.port ^ 4'd1);
            else if (r < 97)
                it.pair = PAIR_W'($urandom_range(0, 16));
            else
                it.pair = PAIR_W'($urandom_range(17, 31));
            return it;
        end
        // Pick which change bits are set
        r = $urandom_range(0, 99);
        if (r < 5)
            {it.cc, it.rc, it.ce} = 3'b000;
        else if (r < 13)
            it.ce = 1'b1;
        else if (r < 40)
            {it.rc, it.ce} = 2'b10;
        else
            {it.cc, it.rc, it.ce} = 3'b100;
        it.conn  = ($urandom_range(0, 99) < 70);
        it.en    = ($urandom_range(0, 99) < 80);
        it.speed = ($urandom_range(0, 99) < 20) ? '0 : SPEED_W'($urandom_range(1, 15));
        it.seen  = ($urandom_range(0, 99) < 35);
        return it;
    endfunction

    // Offer one transaction and hold it until taken, then idle at random
    task automatic send_item(input port_item_t it, input logic typed,
                             input port_result_t res);
        int n;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {3'b000, it.seen, it.speed, it.en, it.conn, it.ce, it.rc,
                          it.cc, it.pair, it.proto, it.port};
        typed_row     <= typed;
        typed_res     <= res;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n = calm ? 0 : idle_len();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Check results and predict on every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                taken_res.state = m_axis_tdata[STATE_W-1:0];
                taken_res.act   = m_axis_tdata[STATE_W+ACT_W-1:STATE_W];
                taken_res.cls   = m_axis_tdata[STATE_W+ACT_W+CLS_W-1:STATE_W+ACT_W];
                if (expected_status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want_res = expected_status_q.pop_front();
                    report_field("new_state", int'(want_res.state), int'(taken_res.state));
                    report_field("action", int'(want_res.act), int'(taken_res.act));
                    report_field("event_class", int'(want_res.cls), int'(taken_res.cls));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_item.mode  = s_axis_tuser[0];
                taken_item.port  = s_axis_tdata[3:0];
                taken_item.proto = s_axis_tdata[5:4];
                taken_item.pair  = s_axis_tdata[10:6];
                taken_item.cc    = s_axis_tdata[11];
                taken_item.rc    = s_axis_tdata[12];
                taken_item.ce    = s_axis_tdata[13];
                taken_item.conn  = s_axis_tdata[14];
                taken_item.en    = s_axis_tdata[15];
                taken_item.speed = s_axis_tdata[19:16];
                taken_item.seen  = s_axis_tdata[20];
                taken_res = advance_port(taken_item);
                expected_status_q.push_back(typed_row ? typed_res : taken_res);
            end
        end
    end

    // Receiver: random back-pressure, plus one long counted hold-off on request
    initial
    begin
        int n;
        m_axis_tready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = calm ? 0 : idle_len();
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Sender: reset, directed plan, then random traffic
    initial
    begin
        port_result_t none_res;
        none_res      = '0;
        errors        = 0;
        hold_req      = 1'b0;
        calm          = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        typed_row     <= 1'b0;
        typed_res     <= '0;
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            state_tbl[i] = ST_IDLE;
            kind_tbl[i]  = KIND_NONE;
            pair_tbl[i]  = NO_PAIR;
        end

        // Directed plan: item, typed flag, typed result
        // No change bit straight after reset
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd0, 2'd0, 5'd0, 1'b0, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd15, 1'b1}, 1'b1, port_result_t'{ST_IDLE, ACT_NONE, EV_NONE}});
        // Config error wins over every other bit, top port
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd15, 2'd3, 5'd31, 1'b1, 1'b1,
            1'b1, 1'b1, 1'b1, 4'd15, 1'b1}, 1'b1, port_result_t'{ST_IDLE, ACT_WARN, EV_CFG}});
        // Reset change outside resetting wins over connect
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd3, 2'd0, 5'd0, 1'b1, 1'b1,
            1'b0, 1'b1, 1'b1, 4'd15, 1'b0}, 1'b1, port_result_t'{ST_IDLE, ACT_WARN, EV_RST}});
        // Disconnect on an idle unpaired port
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd2, 2'd0, 5'd16, 1'b1, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b1, port_result_t'{ST_IDLE, ACT_WARN, EV_CONN}});
        // Connect on a port that is not present is reset
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd2, 2'd0, 5'd16, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b0, 4'd0, 1'b0}, 1'b1, port_result_t'{ST_RESET, ACT_RESET, EV_CONN}});
        // Load a USB2/USB3 pair on ports 1 and 5
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd1, KIND_USB2, 5'd5, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b1, port_result_t'{ST_IDLE, ACT_NONE, EV_NONE}});
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd5, KIND_USB3, 5'd1, 1'b1, 1'b1,
            1'b1, 1'b1, 1'b1, 4'd15, 1'b1}, 1'b1, port_result_t'{ST_IDLE, ACT_NONE, EV_NONE}});
        // USB2 yields to its pair, then disconnects from spurious
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd4, 1'b1}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b0, 1'b1, 4'd4, 1'b0}, 1'b0, none_res});
        // USB3 connect with and without a speed
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd5, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd15, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd5, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd0, 1'b0}, 1'b0, none_res});
        // USB2 connect without the pair, then reset done with no speed
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b0, 1'b1,
            1'b0, 1'b1, 1'b1, 4'd0, 1'b0}, 1'b0, none_res});
        // Reset again, then reset done with a speed
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd9, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b0, 1'b1,
            1'b0, 1'b1, 1'b1, 4'd9, 1'b0}, 1'b0, none_res});
        // USB3 side while its pair is resetting
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd5, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd15, 1'b0}, 1'b0, none_res});
        // Kind code 3 with a pair beyond the table
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd6, 2'd3, 5'd31, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd6, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd15, 1'b1}, 1'b0, none_res});
        // Port paired with itself
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd7, KIND_USB2, 5'd7, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd7, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd3, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd7, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b0, 1'b1, 4'd3, 1'b0}, 1'b0, none_res});
        // USB2 connect while its pair is spurious
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd10, KIND_USB2, 5'd11, 1'b0,
            1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd11, KIND_USB2, 5'd12, 1'b0,
            1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd11, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd1, 1'b1}, 1'b0, none_res});
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd10, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b1, 1'b1, 4'd1, 1'b0}, 1'b0, none_res});
        // Disconnect of an active port
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd2, 2'd0, 5'd0, 1'b1, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b0, none_res});
        // Config error drops an active port to idle; pair index zero
        plan.push_back(plan_row_t'{port_item_t'{MODE_EVENT, 4'd1, 2'd0, 5'd0, 1'b0, 1'b0,
            1'b1, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b1, port_result_t'{ST_IDLE, ACT_WARN, EV_CFG}});
        plan.push_back(plan_row_t'{port_item_t'{MODE_LOAD, 4'd15, KIND_USB3, 5'd0, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0, 4'd0, 1'b0}, 1'b1, port_result_t'{ST_IDLE, ACT_NONE, EV_NONE}});

        // Hold reset, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].res);

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            // Long receiver hold-off while the sender keeps offering
            if (k == 500)
                hold_req = 1'b1;
            // Stretch with no idling on either side
            calm = (k >= 800 && k < 950);
            // Pause until every pending result has come back
            if (k == 1200)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_status_q.size() != 0)
                    @(posedge clk);
            end
            send_item(random_item(), 1'b0, none_res);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain and settle
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/upcsm_pkg.sv
hw/rtl/upcsm_front.sv
hw/rtl/upcsm_queue.sv
hw/rtl/upcsm_back.sv
hw/rtl/usb_port_connection_state_machine_core.sv
tb/sv/tb_usb_port_connection_state_machine_core.sv
